FILE: rtl/core/upq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package upq_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;
  localparam int CAP_W  = 5;

  localparam logic       OP_INSERT = 1'b0;
  localparam logic       OP_DELETE = 1'b1;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] priority_req;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] top_data;
    logic signed [DATA_W-1:0] top_priority;
  } res_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/core/upq_store.sv
`timescale 1ns / 1ps
`default_nettype none
module upq_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire upq_pkg::entry_t   wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output upq_pkg::entry_t        rdata
);

  upq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/unsorted_array_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Insert, or any refused item: result in the cycle after acceptance, next item the cycle after.
// Delete: busy while the scan runs, result follows; one pass over the entry
// memory (one read a cycle) both closes the gap and finds the next top entry.
// The receiver cannot stall: each result is shown for exactly one cycle with done.
// Synchronous reset empties the queue and sets the capacity to 16; entry memory is not cleared.
module unsorted_array_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire upq_pkg::cmd_t             cmd,
  output logic                           busy,
  output logic                           done,
  output upq_pkg::res_t                  result,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [upq_pkg::CAP_W-1:0] cfg_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > upq_pkg::CAP_W) ? CW : upq_pkg::CAP_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                          state;
  logic [CW-1:0]                 cnt;
  logic [upq_pkg::CAP_W-1:0]     capacity;
  logic [IW-1:0]                 top_idx;
  upq_pkg::entry_t               top;
  logic [CW-1:0]                 iss;
  logic                          rd_valid;
  logic [IW-1:0]                 rd_idx;
  logic                          have_best;
  upq_pkg::entry_t               best;
  logic [IW-1:0]                 best_idx;

  logic                          accept;
  logic                          full;
  logic                          finish;
  logic                          rd_en;
  logic                          we;
  logic [IW-1:0]                 waddr;
  upq_pkg::entry_t               wdata;
  upq_pkg::entry_t               rdata;
  logic signed [upq_pkg::DATA_W-1:0] cmp_a;
  logic signed [upq_pkg::DATA_W-1:0] cmp_b;
  logic                          gt;
  logic                          take;
  logic                          last;
  logic [IW-1:0]                 new_idx;
  logic                          have_best_next;
  upq_pkg::entry_t               best_next;
  logic [IW-1:0]                 best_idx_next;
  logic [CW-1:0]                 cnt_dec;

  assign busy      = (state == S_SCAN);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign full      = (MW'(cnt) >= MW'(capacity)) || (cnt == CW'(DEPTH));
  assign rd_en     = (state == S_SCAN) && (iss < cnt);
  assign cnt_dec   = cnt - CW'(1);
  assign finish    = (state == S_IDLE) ?
                     (accept && ((cmd.op == upq_pkg::OP_INSERT) || (cnt == '0))) : last;

  // shared priority comparator
  always_comb begin
    if (state == S_SCAN) begin
      cmp_a = rdata.prio;
      cmp_b = best.prio;
    end else begin
      cmp_a = cmd.priority_req;
      cmp_b = top.prio;
    end
  end
  assign gt = cmp_a > cmp_b;

  assign take    = rd_valid && (rd_idx != top_idx) && (!have_best || gt);
  assign last    = rd_valid && (CW'(rd_idx) == cnt_dec);
  assign new_idx = (rd_idx > top_idx) ? (rd_idx - IW'(1)) : rd_idx;

  always_comb begin
    have_best_next = have_best;
    best_next      = best;
    best_idx_next  = best_idx;
    if (take) begin
      have_best_next = 1'b1;
      best_next      = rdata;
      best_idx_next  = new_idx;
    end
  end

  always_comb begin
    if (state == S_SCAN) begin
      we    = rd_valid && (rd_idx > top_idx);
      waddr = rd_idx - IW'(1);
      wdata = rdata;
    end else begin
      we    = accept && (cmd.op == upq_pkg::OP_INSERT) && !full;
      waddr = cnt[IW-1:0];
      wdata = '{data: cmd.data, prio: cmd.priority_req};
    end
  end

  upq_store #(
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (iss[IW-1:0]),
    .rdata (rdata)
  );

  function automatic upq_pkg::res_t make_res(logic [1:0] st, logic [CW-1:0] n,
                                             upq_pkg::entry_t t);
    upq_pkg::res_t r;
    r.status       = st;
    r.count        = upq_pkg::CNT_W'(n);
    r.is_empty     = (n == '0);
    r.top_data     = (n == '0) ? '0 : t.data;
    r.top_priority = (n == '0) ? '0 : t.prio;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      capacity <= upq_pkg::CAP_W'(16);
      done     <= 1'b0;
      rd_valid <= 1'b0;
      iss      <= '0;
    end else begin
      done     <= finish;
      rd_valid <= rd_en;
      rd_idx   <= iss[IW-1:0];
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.op == upq_pkg::OP_INSERT) begin
              if (full) begin
                result <= make_res(upq_pkg::ST_FULL, cnt, top);
              end else begin
                cnt <= cnt + CW'(1);
                if (cnt == '0 || gt) begin
                  top     <= wdata;
                  top_idx <= cnt[IW-1:0];
                  result  <= make_res(upq_pkg::ST_DONE, cnt + CW'(1), wdata);
                end else begin
                  result  <= make_res(upq_pkg::ST_DONE, cnt + CW'(1), top);
                end
              end
            end else if (cnt == '0) begin
              result <= make_res(upq_pkg::ST_EMPTY, cnt, top);
            end else begin
              state     <= S_SCAN;
              iss       <= '0;
              have_best <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            iss <= iss + CW'(1);
          end
          have_best <= have_best_next;
          best      <= best_next;
          best_idx  <= best_idx_next;
          if (last) begin
            state   <= S_IDLE;
            cnt     <= cnt_dec;
            top     <= best_next;
            top_idx <= best_idx_next;
            result  <= make_res(upq_pkg::ST_DONE, cnt_dec, best_next);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: bench/unsorted_array_priority_queue_tb.sv
`timescale 1ns / 1ps
module unsorted_array_priority_queue_tb;

  localparam int DEPTH          = 16;
  localparam int QUIET_LIMIT    = 2000;
  localparam int END_DRAIN      = 2 * DEPTH + 8;
  localparam logic signed [upq_pkg::DATA_W-1:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [upq_pkg::DATA_W-1:0] S_MIN = 32'sh80000000;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      start     = 1'b0;
  upq_pkg::cmd_t             cmd       = '0;
  logic                      busy;
  logic                      done;
  upq_pkg::res_t             result;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [upq_pkg::CAP_W-1:0] cfg_data  = '0;

  logic signed [upq_pkg::DATA_W-1:0] held_data [DEPTH];
  logic signed [upq_pkg::DATA_W-1:0] held_prio [DEPTH];
  int   held_count   = 0;
  int   capacity_reg = 16;

  upq_pkg::res_t awaiting_results[$];
  upq_pkg::res_t want;
  int   errors       = 0;
  int   quiet_cycles = 0;
  bit   idle_enabled = 1'b1;
  int   n_items = 0, n_inserted = 0, n_removed = 0, n_full = 0, n_empty = 0, n_cfg = 0;

  always #4 clk = ~clk;

  unsorted_array_priority_queue #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic int top_slot();
    int best;
    best = 0;
    for (int k = 1; k < held_count; k++) begin
      if (held_prio[k] > held_prio[best]) best = k;
    end
    return best;
  endfunction

  function automatic upq_pkg::res_t apply_queue_op(upq_pkg::cmd_t c);
    upq_pkg::res_t r;
    int   cap;
    int   t;
    r   = '0;
    cap = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    r.status = upq_pkg::ST_DONE;
    if (c.op == upq_pkg::OP_INSERT) begin
      if (held_count >= cap) begin
        r.status = upq_pkg::ST_FULL;
      end else begin
        held_data[held_count] = c.data;
        held_prio[held_count] = c.priority_req;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = upq_pkg::ST_EMPTY;
      end else begin
        t = top_slot();
        for (int k = t; k + 1 < held_count; k++) begin
          held_data[k] = held_data[k + 1];
          held_prio[k] = held_prio[k + 1];
        end
        held_count--;
      end
    end
    r.count    = upq_pkg::CNT_W'(held_count);
    r.is_empty = (held_count == 0);
    if (held_count != 0) begin
      t = top_slot();
      r.top_data     = held_data[t];
      r.top_priority = held_prio[t];
    end
    return r;
  endfunction

  task automatic send_item(upq_pkg::cmd_t c);
    int   gap;
    upq_pkg::res_t r;
    gap = 0;
    if (idle_enabled && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    r = apply_queue_op(c);
    awaiting_results.push_back(r);
    n_items++;
    case (r.status)
      upq_pkg::ST_FULL:  n_full++;
      upq_pkg::ST_EMPTY: n_empty++;
      default: begin
        if (c.op == upq_pkg::OP_INSERT) n_inserted++;
        else n_removed++;
      end
    endcase
  endtask

  task automatic send_insert(logic signed [upq_pkg::DATA_W-1:0] d,
                             logic signed [upq_pkg::DATA_W-1:0] p);
    upq_pkg::cmd_t c;
    c.op           = upq_pkg::OP_INSERT;
    c.data         = d;
    c.priority_req = p;
    send_item(c);
  endtask

  task automatic send_delete();
    upq_pkg::cmd_t c;
    c.op           = upq_pkg::OP_DELETE;
    c.data         = $urandom;
    c.priority_req = $urandom;
    send_item(c);
  endtask

  task automatic go_idle();
    start <= 1'b0;
    while (awaiting_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_capacity(int v);
    go_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= upq_pkg::CAP_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    capacity_reg = v & 31;
    n_cfg++;
  endtask

  function automatic upq_pkg::cmd_t random_cmd(int insert_pct, bit narrow);
    upq_pkg::cmd_t c;
    c.op   = ($urandom_range(0, 99) < insert_pct) ? upq_pkg::OP_INSERT : upq_pkg::OP_DELETE;
    c.data = $urandom;
    case ($urandom_range(0, 15))
      0:       c.priority_req = S_MAX;
      1:       c.priority_req = S_MIN;
      2:       c.data         = ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
      default: c.priority_req = narrow ? (int'($urandom_range(0, 6)) - 3) : $urandom;
    endcase
    if (c.priority_req === 'x) c.priority_req = $urandom;
    return c;
  endfunction

  // ordering, ties and extremes at the reset capacity
  task automatic test_basic_order();
    send_delete();
    send_insert(S_MIN, S_MIN);
    send_insert(S_MAX, S_MAX);
    send_insert(32'sd0, S_MAX);
    send_insert(-32'sd1, 32'sd0);
    send_insert(32'sd1, -32'sd1);
    send_insert(32'sh55555555, 32'shaaaaaaaa);
    send_delete();
    send_delete();
    send_insert(32'shaaaaaaaa, 32'sh55555555);
    repeat (6) send_delete();
    send_delete();
  endtask

  task automatic test_capacity_edges();
    write_capacity(0);
    send_insert(32'sd7, 32'sd7);
    send_delete();
    write_capacity(1);
    send_insert(32'sd11, -32'sd5);
    send_insert(32'sd12, 32'sd9);
    send_delete();
    write_capacity(31);
    for (int i = 0; i < DEPTH + 2; i++) send_insert($urandom, int'($urandom_range(0, 4)) - 2);
    write_capacity(17);
    send_insert(32'sd3, S_MAX);
    // capacity now below the count held
    write_capacity(3);
    send_insert(32'sd4, S_MAX);
    repeat (DEPTH - 2) send_delete();
    send_insert(32'sd5, S_MIN);
    send_insert(32'sd6, S_MAX);
    repeat (4) send_delete();
    write_capacity(16);
  endtask

  task automatic test_random_phases(int n_phases, int per_phase);
    int  cap;
    int  pct;
    bit  narrow;
    for (int p = 0; p < n_phases; p++) begin
      case ($urandom_range(0, 9))
        0:       cap = 16;
        1:       cap = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(17, 31);
        2:       cap = 1;
        default: cap = $urandom_range(1, 16);
      endcase
      write_capacity(cap);
      idle_enabled = ($urandom_range(0, 3) != 0);
      narrow       = 1'($urandom_range(0, 1));
      case (p % 3)
        0:       pct = 75;
        1:       pct = 30;
        default: pct = 55;
      endcase
      for (int i = 0; i < per_phase; i++) send_item(random_cmd(pct, narrow));
    end
  endtask

  task automatic test_back_to_back(int n);
    idle_enabled = 1'b0;
    write_capacity(16);
    for (int i = 0; i < n; i++) send_item(random_cmd((i < n / 2) ? 70 : 35, i[3]));
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaiting_results.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        want = awaiting_results.pop_front();
        if (result.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, result.status);
          errors++;
        end
        if (result.count !== want.count) begin
          $error("count expected %0d actual %0d", want.count, result.count);
          errors++;
        end
        if (result.is_empty !== want.is_empty) begin
          $error("is_empty expected %0d actual %0d", want.is_empty, result.is_empty);
          errors++;
        end
        if (result.top_data !== want.top_data) begin
          $error("top_data expected %0d actual %0d", want.top_data, result.top_data);
          errors++;
        end
        if (result.top_priority !== want.top_priority) begin
          $error("top_priority expected %0d actual %0d", want.top_priority,
                 result.top_priority);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_basic_order();
    test_capacity_edges();
    test_random_phases(14, 55);
    test_back_to_back(100);
    go_idle();
    repeat (END_DRAIN) @(posedge clk);
    $display("%0d items: %0d inserted, %0d removed, %0d refused full, %0d refused empty",
             n_items, n_inserted, n_removed, n_full, n_empty);
    $display("%0d capacity writes incl. 0, 1, 16 and saturating values", n_cfg);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
